### rtl/core/cdq_pkg.sv
// Shared constants, codes and types for the compacting deque of handles.
package cdq_pkg;

  localparam int DEPTH       = 64;
  localparam int HANDLE_BITS = 32;
  localparam int SEQ_BITS    = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CMD_W       = 3;
  localparam int STAT_W      = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TOP      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ZAP      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_COLLAPSE = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,  // cells at or above pos take their upper neighbour
    CELL_LOAD  = 2'd2,  // cell at pos takes the broadcast data
    CELL_ZAP   = 2'd3   // cell at pos nulls its handle
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        pos;
    logic [HANDLE_BITS-1:0]  handle;
    logic [SEQ_BITS-1:0]     seq;
  } cell_ctl_t;

endpackage

### rtl/core/cdq_req_if.sv
// Command channel: valid/ready with the command payload.
interface cdq_req_if;
  logic                             valid;
  logic                             ready;
  logic [cdq_pkg::CMD_W-1:0]        cmd;
  logic [cdq_pkg::HANDLE_BITS-1:0]  handle_in;
  logic [cdq_pkg::SEQ_BITS-1:0]     seq_in;
  logic [cdq_pkg::IDX_W-1:0]        index;

  modport source (output valid, cmd, handle_in, seq_in, index, input ready);
  modport sink   (input valid, cmd, handle_in, seq_in, index, output ready);
endinterface

### rtl/core/cdq_rsp_if.sv
// Result channel: valid/ready with the result payload.
interface cdq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cdq_pkg::STAT_W-1:0]       status;
  logic [cdq_pkg::HANDLE_BITS-1:0]  handle_out;
  logic [cdq_pkg::SEQ_BITS-1:0]     seq_out;
  logic [cdq_pkg::CNT_W-1:0]        entry_count;
  logic [cdq_pkg::SEQ_BITS-1:0]     max_seq;

  modport source (output valid, status, handle_out, seq_out, entry_count, max_seq,
                  input ready);
  modport sink   (input valid, status, handle_out, seq_out, entry_count, max_seq,
                  output ready);
endinterface

### rtl/core/cdq_cell.sv
// One storage cell of the deque: a handle and a sequence number.
module cdq_cell (
  input  logic                             clk,
  input  cdq_pkg::cell_ctl_t               ctl,
  input  logic [cdq_pkg::IDX_W-1:0]        pos,
  input  logic [cdq_pkg::HANDLE_BITS-1:0]  nbr_handle,
  input  logic [cdq_pkg::SEQ_BITS-1:0]     nbr_seq,
  output logic [cdq_pkg::HANDLE_BITS-1:0]  handle,
  output logic [cdq_pkg::SEQ_BITS-1:0]     seq,
  output logic                             is_null
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (pos == ctl.pos);
  assign above_pos = (pos >= ctl.pos);
  assign is_null   = (handle == '0);

  // Payload only, no reset
  always_ff @(posedge clk) begin
    case (ctl.op)
      cdq_pkg::CELL_SHIFT: begin
        if (above_pos) begin
          handle <= nbr_handle;
          seq    <= nbr_seq;
        end
      end
      cdq_pkg::CELL_LOAD: begin
        if (at_pos) begin
          handle <= ctl.handle;
          seq    <= ctl.seq;
        end
      end
      cdq_pkg::CELL_ZAP: begin
        if (at_pos) handle <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/compacting_deque_of_handles.sv
// Top level: command decode, collapse sequencer and result register over a row of cells.
//
// Usage
//   req carries one command per transfer (push at the back, pop at the front
//   or the back, get, top, zap, collapse); rsp returns exactly one result per
//   command with the status, any handle and sequence number read, the entry
//   count afterwards and the running maximum of pushed sequence numbers.
//   Entries live in a row of cells; position 0 is the front. A pop from the
//   front shifts every cell down by one place. The result is registered and
//   shows on rsp in the cycle after the request transfer, so commands other
//   than collapse run at one per cycle while rsp takes each result. Collapse
//   walks the row from position 0, in each step either removing a null entry
//   at the scan point by shifting the cells above it down or stepping past a
//   live one; req is held off until it is done.
//   Reset (rst, synchronous) empties the deque and clears the maximum; cell
//   contents are left as they are and are never read before being written.
//   If rsp stalls, the result waits in its register; req takes no further
//   command until that result has been taken or is taken in the same cycle.
module compacting_deque_of_handles (
  input  logic       clk,
  input  logic       rst,
  cdq_req_if.sink    req,
  cdq_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_COLL = 2'b10
  } state_t;

  state_t                             state;
  logic [cdq_pkg::CNT_W-1:0]          count;
  logic [cdq_pkg::CNT_W-1:0]          count_next;
  logic [cdq_pkg::SEQ_BITS-1:0]       max_seen;
  logic [cdq_pkg::SEQ_BITS-1:0]       max_seen_next;
  logic [cdq_pkg::CNT_W-1:0]          scan;

  logic                               out_valid;
  logic [cdq_pkg::STAT_W-1:0]         out_status;
  logic [cdq_pkg::HANDLE_BITS-1:0]    out_handle;
  logic [cdq_pkg::SEQ_BITS-1:0]       out_seq;
  logic [cdq_pkg::CNT_W-1:0]          out_count;

  logic                               out_free;
  logic                               req_xfer;
  logic                               res_load;
  logic [cdq_pkg::STAT_W-1:0]         res_status;
  logic [cdq_pkg::HANDLE_BITS-1:0]    res_handle;
  logic [cdq_pkg::SEQ_BITS-1:0]       res_seq;

  logic [cdq_pkg::HANDLE_BITS-1:0]    cell_h [cdq_pkg::DEPTH];
  logic [cdq_pkg::SEQ_BITS-1:0]       cell_s [cdq_pkg::DEPTH];
  logic [cdq_pkg::DEPTH-1:0]          cell_null;
  cdq_pkg::cell_ctl_t                 ctl;

  logic                               is_empty;
  logic                               is_full;
  logic                               idx_bad;
  logic [cdq_pkg::CNT_W-1:0]          last_cnt;
  logic [cdq_pkg::IDX_W-1:0]          rd_pos;
  logic                               scan_done;

  // Row of cells, each fed by its upper neighbour
  for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
    logic [cdq_pkg::HANDLE_BITS-1:0] nh;
    logic [cdq_pkg::SEQ_BITS-1:0]    ns;
    if (i == cdq_pkg::DEPTH - 1) begin : g_end
      assign nh = '0;
      assign ns = '0;
    end else begin : g_mid
      assign nh = cell_h[i+1];
      assign ns = cell_s[i+1];
    end
    cdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (cdq_pkg::IDX_W'(i)),
      .nbr_handle (nh),
      .nbr_seq    (ns),
      .handle     (cell_h[i]),
      .seq        (cell_s[i]),
      .is_null    (cell_null[i])
    );
  end

  // Handshake
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign req_xfer  = req.valid && req.ready;

  // Shared decode terms
  assign is_empty  = (count == '0);
  assign is_full   = (count == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
  assign idx_bad   = (cdq_pkg::CNT_W'(req.index) >= count);
  assign last_cnt  = count - cdq_pkg::CNT_W'(1);
  assign rd_pos    = (req.cmd == cdq_pkg::CMD_GET) ? req.index
                                                   : last_cnt[cdq_pkg::IDX_W-1:0];
  assign scan_done = (scan >= count);

  // Command decode and collapse steps
  always_comb begin
    ctl           = '{op: cdq_pkg::CELL_HOLD, pos: '0, handle: req.handle_in,
                      seq: req.seq_in};
    count_next    = count;
    max_seen_next = max_seen;
    res_load      = 1'b0;
    res_status    = cdq_pkg::ST_OK;
    res_handle    = '0;
    res_seq       = '0;

    if (state == S_IDLE) begin
      if (req_xfer) begin
        res_load = 1'b1;
        case (req.cmd)
          cdq_pkg::CMD_PUSH: begin
            if (is_full) begin
              res_status = cdq_pkg::ST_FULL;
            end else begin
              ctl.op     = cdq_pkg::CELL_LOAD;
              ctl.pos    = count[cdq_pkg::IDX_W-1:0];
              count_next = count + cdq_pkg::CNT_W'(1);
              if (req.seq_in > max_seen) max_seen_next = req.seq_in;
            end
          end
          cdq_pkg::CMD_POP_HEAD: begin
            if (is_empty) begin
              res_status = cdq_pkg::ST_EMPTY;
            end else begin
              res_handle = cell_h[0];
              res_seq    = cell_s[0];
              ctl.op     = cdq_pkg::CELL_SHIFT;
              ctl.pos    = '0;
              count_next = last_cnt;
            end
          end
          cdq_pkg::CMD_POP_TAIL: begin
            if (is_empty) begin
              res_status = cdq_pkg::ST_EMPTY;
            end else begin
              res_handle = cell_h[rd_pos];
              res_seq    = cell_s[rd_pos];
              count_next = last_cnt;
            end
          end
          cdq_pkg::CMD_GET: begin
            if (idx_bad) begin
              res_status = cdq_pkg::ST_RANGE;
            end else begin
              res_handle = cell_h[rd_pos];
              res_seq    = cell_s[rd_pos];
            end
          end
          cdq_pkg::CMD_TOP: begin
            if (is_empty) begin
              res_status = cdq_pkg::ST_EMPTY;
            end else begin
              res_handle = cell_h[rd_pos];
              res_seq    = cell_s[rd_pos];
            end
          end
          cdq_pkg::CMD_ZAP: begin
            if (idx_bad) begin
              res_status = cdq_pkg::ST_RANGE;
            end else begin
              ctl.op  = cdq_pkg::CELL_ZAP;
              ctl.pos = req.index;
            end
          end
          cdq_pkg::CMD_COLLAPSE: begin
            res_load = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end else begin
      // Collapse: drop the null entry at the scan point, or step past a live one
      if (scan_done) begin
        res_load = out_free;
      end else if (cell_null[scan[cdq_pkg::IDX_W-1:0]]) begin
        ctl.op     = cdq_pkg::CELL_SHIFT;
        ctl.pos    = scan[cdq_pkg::IDX_W-1:0];
        count_next = last_cnt;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      max_seen <= '0;
      scan     <= '0;
    end else begin
      count    <= count_next;
      max_seen <= max_seen_next;
      case (state)
        S_IDLE: begin
          if (req_xfer && req.cmd == cdq_pkg::CMD_COLLAPSE) begin
            state <= S_COLL;
            scan  <= '0;
          end
        end
        S_COLL: begin
          if (scan_done) begin
            if (out_free) state <= S_IDLE;
          end else if (!cell_null[scan[cdq_pkg::IDX_W-1:0]]) begin
            scan <= scan + cdq_pkg::CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_handle <= res_handle;
      out_seq    <= res_seq;
      out_count  <= count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.handle_out  = out_handle;
  assign rsp.seq_out     = out_seq;
  assign rsp.entry_count = out_count;
  assign rsp.max_seq     = max_seen;

endmodule
